### rtl/core/vpa_pkg.sv
// shared types and constants for the variable partition allocator
// used by vpa_ctrl, vpa_dpath and variable_partition_allocator
package vpa_pkg;

	localparam int MaxSegments = 16;
	localparam int IdxW = $clog2(MaxSegments);
	localparam int CntW = $clog2(MaxSegments + 1);

	localparam logic [15:0] ResetTotal = 16'd640;

	// configuration register indexes
	localparam logic CFG_TOTAL_SIZE = 1'b0;
	localparam logic CFG_FIT_POLICY = 1'b1;

	// fit policies; the unused code acts as first fit
	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	// request kinds
	localparam logic ACT_ALLOC   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_FIT    = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_ZERO      = 3'd4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY,
		S_DONE
	} vpa_state_t;

	typedef struct packed {
		logic start;
		logic step;
		logic apply;
		logic load;
	} vpa_cmd_t;

	typedef struct packed {
		logic scan_last;
	} vpa_stat_t;

endpackage

### rtl/core/vpa_dpath.sv
// segment table, scan registers and table update for the partition allocator
// depends on vpa_pkg; driven by vpa_ctrl through vpa_cmd_t
module vpa_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                req_action,
	input  logic [7:0]          req_owner,
	input  logic [15:0]         req_size,
	input  vpa_pkg::vpa_cmd_t   cmd,
	output vpa_pkg::vpa_stat_t  stat,
	output logic [2:0]          res_status,
	output logic [15:0]         res_base,
	output logic [15:0]         res_done
);

	localparam int N = vpa_pkg::MaxSegments;
	localparam int IW = vpa_pkg::IdxW;
	localparam int CW = vpa_pkg::CntW;

	logic [7:0]  owner_q [N];
	logic [15:0] size_q [N];
	logic [CW-1:0] count_q;
	logic [1:0]  policy_q;

	logic        act_q;
	logic [7:0]  own_q;
	logic [15:0] rsz_q;

	logic [IW-1:0] idx_q;
	logic [15:0] run_q;
	logic        found_q;
	logic [IW-1:0] pick_q;
	logic [15:0] psize_q;
	logic [15:0] poff_q;
	logic        prev_free_q;
	logic [15:0] prev_size_q;
	logic        last_free_q;
	logic [15:0] last_size_q;
	logic        next_free_q;
	logic [15:0] next_size_q;

	logic [2:0]  st_q;
	logic [15:0] base_q;
	logic [15:0] done_q;
	logic [2:0]  out_status_q;
	logic [15:0] out_base_q;
	logic [15:0] out_done_q;

	logic [7:0]  cur_own;
	logic [15:0] cur_size;
	logic        better;
	logic        take;
	logic        at_next;

	logic [2:0]  st_c;
	logic        wr_exact;
	logic        wr_split;
	logic        wr_rel;
	logic        rel_l;
	logic        rel_r;
	logic [7:0]  own_nx [N];
	logic [15:0] size_nx [N];
	logic [CW-1:0] count_nx;
	logic        tbl_wr;

	assign cur_own  = owner_q[idx_q];
	assign cur_size = size_q[idx_q];

	assign stat.scan_last = ({1'b0, idx_q} + CW'(1)) >= count_q;

	always_comb begin
		priority if (!found_q) begin
			better = 1'b1;
		end else if (policy_q == vpa_pkg::POL_BEST) begin
			better = cur_size < psize_q;
		end else if (policy_q == vpa_pkg::POL_WORST) begin
			better = cur_size > psize_q;
		end else begin
			better = 1'b0;
		end
	end

	assign take = (act_q == vpa_pkg::ACT_ALLOC) ?
		((cur_own == 8'd0) && (cur_size >= rsz_q) && better) :
		((cur_own == own_q) && !found_q);

	assign at_next = found_q && ({1'b0, idx_q} == ({1'b0, pick_q} + (IW+1)'(1)));

	// scan and request registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.start) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.step) begin
			idx_q <= idx_q + IW'(1);
			if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			act_q       <= req_action;
			own_q       <= req_owner;
			rsz_q       <= req_size;
			run_q       <= '0;
			last_free_q <= 1'b0;
			last_size_q <= '0;
			next_free_q <= 1'b0;
			next_size_q <= '0;
			pick_q      <= '0;
			psize_q     <= '0;
			poff_q      <= '0;
			prev_free_q <= 1'b0;
			prev_size_q <= '0;
		end else if (cmd.step) begin
			if (take) begin
				pick_q      <= idx_q;
				psize_q     <= cur_size;
				poff_q      <= run_q;
				prev_free_q <= (idx_q != '0) && last_free_q;
				prev_size_q <= last_size_q;
			end
			// neighbor above a released segment
			if (act_q == vpa_pkg::ACT_RELEASE && at_next) begin
				next_free_q <= cur_own == 8'd0;
				next_size_q <= cur_size;
			end
			last_free_q <= cur_own == 8'd0;
			last_size_q <= cur_size;
			run_q       <= run_q + cur_size;
		end
	end

	// outcome of the request
	always_comb begin
		wr_exact = 1'b0;
		wr_split = 1'b0;
		wr_rel   = 1'b0;
		if (act_q == vpa_pkg::ACT_ALLOC) begin
			priority if (rsz_q == 16'd0) begin
				st_c = vpa_pkg::ST_ZERO;
			end else if (own_q == 8'd0) begin
				st_c = vpa_pkg::ST_NOT_FOUND;
			end else if (!found_q) begin
				st_c = vpa_pkg::ST_NO_FIT;
			end else if (psize_q == rsz_q) begin
				st_c = vpa_pkg::ST_OK;
				wr_exact = 1'b1;
			end else if (count_q >= CW'(N)) begin
				st_c = vpa_pkg::ST_FULL;
			end else begin
				st_c = vpa_pkg::ST_OK;
				wr_split = 1'b1;
			end
		end else begin
			if (own_q == 8'd0 || !found_q) begin
				st_c = vpa_pkg::ST_NOT_FOUND;
			end else begin
				st_c = vpa_pkg::ST_OK;
				wr_rel = 1'b1;
			end
		end
	end

	assign rel_l = prev_free_q;
	assign rel_r = next_free_q;
	assign tbl_wr = wr_exact || wr_split || wr_rel;

	// next table contents, each entry from itself, a fixed neighbor or a split or merged size
	always_comb begin
		logic [IW:0] jj;
		logic [IW:0] pk;
		count_nx = count_q;
		pk = {1'b0, pick_q};
		for (int j = 0; j < N; j++) begin
			jj = (IW+1)'(j);
			own_nx[j]  = owner_q[j];
			size_nx[j] = size_q[j];
			if (wr_exact) begin
				if (jj == pk) begin
					own_nx[j] = own_q;
				end
			end else if (wr_split) begin
				if (jj == pk) begin
					own_nx[j]  = own_q;
					size_nx[j] = rsz_q;
				end else if (jj == pk + (IW+1)'(1)) begin
					own_nx[j]  = 8'd0;
					size_nx[j] = psize_q - rsz_q;
				end else if (jj > pk + (IW+1)'(1)) begin
					if (j > 0) begin
						own_nx[j]  = owner_q[j-1];
						size_nx[j] = size_q[j-1];
					end
				end
			end else if (wr_rel) begin
				if (rel_l && rel_r) begin
					if (jj + (IW+1)'(1) == pk) begin
						size_nx[j] = prev_size_q + psize_q + next_size_q;
					end else if (jj >= pk) begin
						own_nx[j]  = (j + 2 < N) ? owner_q[(j+2) % N] : 8'd0;
						size_nx[j] = (j + 2 < N) ? size_q[(j+2) % N] : 16'd0;
					end
				end else if (rel_l) begin
					if (jj + (IW+1)'(1) == pk) begin
						size_nx[j] = prev_size_q + psize_q;
					end else if (jj >= pk) begin
						own_nx[j]  = (j + 1 < N) ? owner_q[(j+1) % N] : 8'd0;
						size_nx[j] = (j + 1 < N) ? size_q[(j+1) % N] : 16'd0;
					end
				end else if (rel_r) begin
					if (jj == pk) begin
						own_nx[j]  = 8'd0;
						size_nx[j] = psize_q + next_size_q;
					end else if (jj > pk) begin
						own_nx[j]  = (j + 1 < N) ? owner_q[(j+1) % N] : 8'd0;
						size_nx[j] = (j + 1 < N) ? size_q[(j+1) % N] : 16'd0;
					end
				end else begin
					if (jj == pk) begin
						own_nx[j] = 8'd0;
					end
				end
			end
		end
		if (wr_split) begin
			count_nx = count_q + CW'(1);
		end else if (wr_rel && rel_l && rel_r) begin
			count_nx = count_q - CW'(2);
		end else if (wr_rel && (rel_l || rel_r)) begin
			count_nx = count_q - CW'(1);
		end
	end

	// segment table and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < N; j++) begin
				owner_q[j] <= 8'd0;
				size_q[j]  <= (j == 0) ? vpa_pkg::ResetTotal : 16'd0;
			end
			count_q  <= CW'(1);
			policy_q <= vpa_pkg::POL_FIRST;
		end else if (cfg_wr) begin
			if (cfg_index == vpa_pkg::CFG_TOTAL_SIZE) begin
				for (int j = 0; j < N; j++) begin
					owner_q[j] <= 8'd0;
					size_q[j]  <= (j == 0) ? cfg_data : 16'd0;
				end
				count_q <= CW'(1);
			end else begin
				policy_q <= cfg_data[1:0];
			end
		end else if (cmd.apply && tbl_wr) begin
			for (int j = 0; j < N; j++) begin
				owner_q[j] <= own_nx[j];
				size_q[j]  <= size_nx[j];
			end
			count_q <= count_nx;
		end
	end

	// result, then output register
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			st_q   <= st_c;
			base_q <= (st_c == vpa_pkg::ST_OK) ? poff_q : 16'd0;
			if (st_c != vpa_pkg::ST_OK) begin
				done_q <= 16'd0;
			end else if (act_q == vpa_pkg::ACT_ALLOC) begin
				done_q <= rsz_q;
			end else begin
				done_q <= psize_q;
			end
		end
		if (cmd.load) begin
			out_status_q <= st_q;
			out_base_q   <= base_q;
			out_done_q   <= done_q;
		end
	end

	assign res_status = out_status_q;
	assign res_base   = out_base_q;
	assign res_done   = out_done_q;

endmodule

### rtl/core/vpa_ctrl.sv
// request sequencer for the partition allocator: accept, scan, update, hand off
// depends on vpa_pkg; commands vpa_dpath
module vpa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  vpa_pkg::vpa_stat_t  stat,
	output vpa_pkg::vpa_cmd_t   cmd
);

	vpa_pkg::vpa_state_t state_q;
	vpa_pkg::vpa_state_t state_nx;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			vpa_pkg::S_IDLE: begin
				if (in_valid) begin
					state_nx = vpa_pkg::S_SCAN;
				end
			end
			vpa_pkg::S_SCAN: begin
				if (stat.scan_last) begin
					state_nx = vpa_pkg::S_APPLY;
				end
			end
			vpa_pkg::S_APPLY: begin
				state_nx = vpa_pkg::S_DONE;
			end
			vpa_pkg::S_DONE: begin
				if (out_free) begin
					state_nx = vpa_pkg::S_IDLE;
				end
			end
			default: begin
				state_nx = vpa_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.start = (state_q == vpa_pkg::S_IDLE) && in_valid;
		cmd.step  = state_q == vpa_pkg::S_SCAN;
		cmd.apply = state_q == vpa_pkg::S_APPLY;
		cmd.load  = (state_q == vpa_pkg::S_DONE) && out_free;
		in_ready  = state_q == vpa_pkg::S_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vpa_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/core/variable_partition_allocator.sv
// variable partition allocator: address-ordered segment table with first,
// best and worst fit allocation and release with neighbor merging
// depends on vpa_pkg, vpa_ctrl and vpa_dpath
//
// requests arrive on the s_ stream: s_tuser is the action (0 allocate,
// 1 release), s_tdata carries owner id and size. every request gives one
// result on the m_ stream: status, base offset and size granted or released.
// one request is in work at a time. the scan reads one table entry per cycle,
// over every segment in the table; then the apply state updates the table and
// the done state loads the result into the output register, raising m_tvalid.
// s_tready returns in the cycle m_tvalid rises, and a new request is taken
// while a result waits in that register.
// when m_tready is low the result holds in the output register and the next
// finished request waits in its last state until that register frees up.
// the cfg channel is always ready: index 0 writes total_size and resets the
// table to one free segment, index 1 writes fit_policy. write it only while
// no request is in work. after reset the table holds one free segment of
// 640 units, first fit is selected and no result is pending.
module variable_partition_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // owner_id[7:0], request_size[23:8]
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // status[2:0], base_offset[18:3], done_size[34:19], zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	vpa_pkg::vpa_cmd_t  cmd;
	vpa_pkg::vpa_stat_t stat;
	logic [2:0]  res_status;
	logic [15:0] res_base;
	logic [15:0] res_done;

	assign cfg_ready = 1'b1;

	vpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	vpa_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_action (s_tuser),
		.req_owner  (s_tdata[7:0]),
		.req_size   (s_tdata[23:8]),
		.cmd        (cmd),
		.stat       (stat),
		.res_status (res_status),
		.res_base   (res_base),
		.res_done   (res_done)
	);

	assign m_tdata = {5'd0, res_done, res_base, res_status};

endmodule

### tb/tb_variable_partition_allocator.sv
// testbench for variable_partition_allocator: directed special cases, then random
// allocate/release traffic under each fit policy, checked against a table model
// depends on vpa_pkg and the variable_partition_allocator rtl
module tb_variable_partition_allocator;

	localparam logic [1:0] POL_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 25;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] base;
		logic [15:0] size;
	} grant_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [39:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	// segment table as the block should hold it
	logic [7:0]  seg_owner [vpa_pkg::MaxSegments];
	logic [15:0] seg_size [vpa_pkg::MaxSegments];
	int          seg_count;
	logic [15:0] total_units;
	logic [1:0]  policy;

	grant_t pending_grants [$];
	int     mismatches = 0;
	int     idle_pct = 0;
	int     stall_pct = 0;

	variable_partition_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic void reset_table();
		for (int i = 0; i < vpa_pkg::MaxSegments; i++) begin
			seg_owner[i] = '0;
			seg_size[i] = '0;
		end
		seg_size[0] = total_units;
		seg_count = 1;
	endfunction

	function automatic logic [15:0] offset_below(int idx);
		logic [15:0] sum;
		sum = '0;
		for (int i = 0; i < idx; i++) sum += seg_size[i];
		return sum;
	endfunction

	function automatic void drop_entry(int idx);
		for (int i = idx; i + 1 < seg_count; i++) begin
			seg_owner[i] = seg_owner[i + 1];
			seg_size[i] = seg_size[i + 1];
		end
		seg_count--;
		seg_owner[seg_count] = '0;
		seg_size[seg_count] = '0;
	endfunction

	// applies one request to the table and returns the grant it should produce
	function automatic grant_t table_update(logic act, logic [7:0] own, logic [15:0] sz);
		grant_t g;
		int pick;
		bit stop;
		g = '0;
		g.status = vpa_pkg::ST_OK;
		pick = -1;
		stop = 1'b0;
		if (act == vpa_pkg::ACT_ALLOC) begin
			if (sz == 0) begin
				g.status = vpa_pkg::ST_ZERO;
			end else if (own == 0) begin
				g.status = vpa_pkg::ST_NOT_FOUND;
			end else begin
				for (int i = 0; i < seg_count && !stop; i++) begin
					if (seg_owner[i] == 0 && seg_size[i] >= sz) begin
						if (pick < 0) begin
							pick = i;
							// first fit and the spare code stop at the first hit
							stop = (policy != vpa_pkg::POL_BEST &&
								policy != vpa_pkg::POL_WORST);
						end else if (policy == vpa_pkg::POL_BEST &&
								seg_size[i] < seg_size[pick]) begin
							pick = i;
						end else if (policy == vpa_pkg::POL_WORST &&
								seg_size[i] > seg_size[pick]) begin
							pick = i;
						end
					end
				end
				if (pick < 0) begin
					g.status = vpa_pkg::ST_NO_FIT;
				end else if (seg_size[pick] != sz && seg_count >= vpa_pkg::MaxSegments) begin
					g.status = vpa_pkg::ST_FULL;
				end else begin
					if (seg_size[pick] != sz) begin
						for (int i = seg_count; i > pick + 1; i--) begin
							seg_owner[i] = seg_owner[i - 1];
							seg_size[i] = seg_size[i - 1];
						end
						seg_owner[pick + 1] = '0;
						seg_size[pick + 1] = seg_size[pick] - sz;
						seg_size[pick] = sz;
						seg_count++;
					end
					seg_owner[pick] = own;
					g.base = offset_below(pick);
					g.size = sz;
				end
			end
		end else begin
			if (own != 0) begin
				for (int i = 0; i < seg_count && pick < 0; i++) begin
					if (seg_owner[i] == own) pick = i;
				end
			end
			if (pick < 0) begin
				g.status = vpa_pkg::ST_NOT_FOUND;
			end else begin
				g.base = offset_below(pick);
				g.size = seg_size[pick];
				seg_owner[pick] = '0;
				if (pick > 0 && seg_owner[pick - 1] == 0) begin
					seg_size[pick - 1] += seg_size[pick];
					drop_entry(pick);
					pick--;
				end
				if (pick + 1 < seg_count && seg_owner[pick + 1] == 0) begin
					seg_size[pick] += seg_size[pick + 1];
					drop_entry(pick + 1);
				end
			end
		end
		return g;
	endfunction

	task automatic note_failure(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("%s", msg);
	endtask

	always @(posedge clk) begin : check_grants
		grant_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_grants.size() == 0) begin
				note_failure($sformatf("unexpected result status=%0d base=%0d size=%0d",
					m_tdata[2:0], m_tdata[18:3], m_tdata[34:19]));
			end else begin
				want = pending_grants.pop_front();
				if (m_tdata[2:0] != want.status || m_tdata[18:3] != want.base ||
						m_tdata[34:19] != want.size) begin
					note_failure($sformatf(
						"mismatch: expected status=%0d base=%0d size=%0d, got %0d %0d %0d",
						want.status, want.base, want.size,
						m_tdata[2:0], m_tdata[18:3], m_tdata[34:19]));
				end
			end
		end
	end

	task automatic send_request(input logic act, input logic [7:0] own, input logic [15:0] sz);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {sz, own};
		do @(posedge clk); while (!s_tready);
		pending_grants.push_back(table_update(act, own, sz));
	endtask

	// wait until every result is back and the block has gone quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [15:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == vpa_pkg::CFG_TOTAL_SIZE) begin
			total_units = value;
			reset_table();
		end else begin
			policy = value[1:0];
		end
	endtask

	task automatic configure(input logic [15:0] total, input logic [1:0] pol);
		logic [13:0] junk;
		junk = 14'($urandom);
		write_register(vpa_pkg::CFG_TOTAL_SIZE, total);
		// upper data bits are don't-care for the policy register
		write_register(vpa_pkg::CFG_FIT_POLICY, {junk, pol});
	endtask

	task automatic traffic_phase(input logic [15:0] total, input logic [1:0] pol,
			input int idle, input int stall, input int count);
		logic [7:0] owners [8];
		int picks [$];
		int r;
		logic act;
		logic [7:0] own;
		logic [15:0] sz;
		configure(total, pol);
		idle_pct = idle;
		stall_pct = stall;
		// a small owner pool so ids repeat and releases find their segments
		foreach (owners[k]) owners[k] = 8'($urandom_range(1, 255));
		repeat (count) begin
			r = $urandom_range(99);
			act = vpa_pkg::ACT_ALLOC;
			own = owners[3'($urandom_range(7))];
			sz = 16'($urandom_range(1, total_units / 8 + 1));
			picks.delete();
			if (r < 3) begin
				sz = '0;
			end else if (r < 5) begin
				own = '0;
				act = 1'($urandom_range(1));
			end else if (r < 7) begin
				sz = 16'($urandom);
			end else if (r < 50) begin
				act = vpa_pkg::ACT_RELEASE;
				sz = 16'($urandom);
				if (r < 45) begin
					for (int i = 0; i < seg_count; i++)
						if (seg_owner[i] != 0) picks.push_back(int'(seg_owner[i]));
					if (picks.size() != 0) own = 8'(picks[$urandom_range(picks.size() - 1)]);
				end
			end else if (r < 60) begin
				// exact fit of some free segment
				for (int i = 0; i < seg_count; i++)
					if (seg_owner[i] == 0 && seg_size[i] != 0) picks.push_back(int'(seg_size[i]));
				if (picks.size() != 0) sz = 16'(picks[$urandom_range(picks.size() - 1)]);
			end else if (r < 70) begin
				sz = 16'($urandom_range(1, (total_units != 0) ? total_units : 1));
			end
			send_request(act, own, sz);
		end
		idle_pct = 0;
		stall_pct = 0;
	endtask

	task automatic test_special_cases();
		send_request(vpa_pkg::ACT_ALLOC, 8'd1, 16'd0);
		send_request(vpa_pkg::ACT_ALLOC, 8'd0, 16'd5);
		send_request(vpa_pkg::ACT_RELEASE, 8'd0, 16'd0);
		send_request(vpa_pkg::ACT_RELEASE, 8'd7, 16'hffff);
		send_request(vpa_pkg::ACT_ALLOC, 8'd255, 16'hffff);
		send_request(vpa_pkg::ACT_ALLOC, 8'd255, 16'd640);
		send_request(vpa_pkg::ACT_RELEASE, 8'd255, 16'd0);
	endtask

	task automatic test_full_table();
		configure(16'd640, vpa_pkg::POL_FIRST);
		for (int i = 0; i < vpa_pkg::MaxSegments - 1; i++)
			send_request(vpa_pkg::ACT_ALLOC, 8'(i % 5 + 1), 16'd1);
		// table full: a split is refused, an exact fit still lands
		send_request(vpa_pkg::ACT_ALLOC, 8'd200, 16'd2);
		send_request(vpa_pkg::ACT_ALLOC, 8'd200, 16'd625);
		send_request(vpa_pkg::ACT_RELEASE, 8'd1, 16'd0);
	endtask

	task automatic test_zero_total();
		configure(16'd0, vpa_pkg::POL_WORST);
		send_request(vpa_pkg::ACT_ALLOC, 8'd9, 16'd1);
	endtask

	task automatic test_first_fit();
		traffic_phase(16'd640, vpa_pkg::POL_FIRST, 0, 0, 88);
		traffic_phase(16'd500, vpa_pkg::POL_FIRST, 0, 64, 88);
	endtask

	task automatic test_best_fit();
		traffic_phase(16'd100, vpa_pkg::POL_BEST, 64, 0, 88);
		traffic_phase(16'hffff, vpa_pkg::POL_BEST, 30, 30, 88);
	endtask

	task automatic test_worst_fit();
		traffic_phase(16'hffff, vpa_pkg::POL_WORST, 0, 64, 88);
		traffic_phase(16'd3000, vpa_pkg::POL_WORST, 64, 0, 88);
	endtask

	task automatic test_spare_policy();
		traffic_phase(16'd1, POL_SPARE, 30, 30, 88);
		traffic_phase(16'd16, POL_SPARE, 0, 0, 88);
	endtask

	initial begin
		total_units = vpa_pkg::ResetTotal;
		policy = vpa_pkg::POL_FIRST;
		reset_table();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		test_full_table();
		test_zero_total();
		test_first_fit();
		test_best_fit();
		test_worst_fit();
		test_spare_policy();
		settle();
		if (mismatches == 0)
			$display("tb_variable_partition_allocator OK");
		else
			$display("tb_variable_partition_allocator NOT OK");
		$finish;
	end

	initial begin
		#400000;
		$display("tb_variable_partition_allocator NOT OK");
		$finish;
	end

endmodule

### files.f
rtl/core/vpa_pkg.sv
rtl/core/vpa_dpath.sv
rtl/core/vpa_ctrl.sv
rtl/core/variable_partition_allocator.sv
tb/tb_variable_partition_allocator.sv
